// ----- sv/kgc_pkg.sv -----
// Shared types and constants for the keypad gesture classifier.
// Used by kgc_core and keypad_gesture_classifier. No dependencies.
package kgc_pkg;

    // Key codes
    localparam logic [1:0] KEY_UP  = 2'd0;
    localparam logic [1:0] KEY_DN  = 2'd1;
    localparam logic [1:0] KEY_FN  = 2'd2;
    localparam logic [1:0] KEY_BAD = 2'd3;

    // Configuration register indexes
    localparam logic REG_HOLD_THR = 1'b0;
    localparam logic REG_LONG_THR = 1'b1;

    // Threshold reset values in milliseconds
    localparam logic [31:0] HOLD_THR_RST = 32'd500;
    localparam logic [31:0] LONG_THR_RST = 32'd2000;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_TAP       = 3'd1,
        EV_HOLD_BEG  = 3'd2,
        EV_HOLD_END  = 3'd3,
        EV_FN_LONG   = 3'd4,
        EV_CHORD_REV = 3'd5
    } t_event;

    // One request as it sits in the input register
    typedef struct packed {
        logic        kind;      // 1: time tick, 0: key change
        logic [1:0]  key_code;
        logic        is_press;
        logic [31:0] time_ms;
    } t_item;

    // Per-key and latch flags of the classifier
    typedef struct packed {
        logic [2:0] key_pressed;
        logic [2:0] key_holding;
        logic       long_done;
        logic       chord_active;
        logic       chord_done;
    } t_flags;

endpackage

// ----- sv/kgc_core.sv -----
// Combinational gesture decision for one request: next flags, press time
// write enables and the event. Depends on kgc_pkg.
module kgc_core #(
    parameter int TIME_BITS = 32
) (
    input  kgc_pkg::t_item        i_item,
    input  kgc_pkg::t_flags       i_flags,
    input  logic [TIME_BITS-1:0]  i_press_time [3],
    input  logic [31:0]           i_hold_thr,
    input  logic [31:0]           i_long_thr,
    output kgc_pkg::t_flags       o_flags,
    output logic [2:0]            o_time_we,
    output logic [TIME_BITS-1:0]  o_now,
    output kgc_pkg::t_event       o_event,
    output logic [1:0]            o_key
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [CMP_W-1:0]     now_w;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since_up, since_dn, since_fn;
    logic [CMP_W-1:0]     hold_w, long_w;
    logic [1:0]           ge_hold;     // up, down past the hold threshold
    logic                 up_ge_long;
    logic                 fn_ge_long;

    assign now_w = CMP_W'(i_item.time_ms);
    assign now   = now_w[TIME_BITS-1:0];
    assign o_now = now;

    // Durations wrap modulo 2^TIME_BITS
    assign since_up = now - i_press_time[0];
    assign since_dn = now - i_press_time[1];
    assign since_fn = now - i_press_time[2];

    assign hold_w = CMP_W'(i_hold_thr);
    assign long_w = CMP_W'(i_long_thr);

    assign ge_hold[0]  = CMP_W'(since_up) >= hold_w;
    assign ge_hold[1]  = CMP_W'(since_dn) >= hold_w;
    assign up_ge_long  = CMP_W'(since_up) >= long_w;
    assign fn_ge_long  = CMP_W'(since_fn) >= long_w;

    always_comb begin
        logic [1:0] key;
        logic [1:0] other;
        key       = i_item.key_code;
        other     = (key == kgc_pkg::KEY_UP) ? kgc_pkg::KEY_DN : kgc_pkg::KEY_UP;
        o_flags   = i_flags;
        o_time_we = '0;
        o_event   = kgc_pkg::EV_NONE;
        o_key     = key;

        if (i_item.kind) begin
            // Tick: function long press first, then chord, then up/down holds
            o_key = kgc_pkg::KEY_UP;
            if (i_flags.key_pressed[2] && !i_flags.long_done && fn_ge_long) begin
                o_flags.long_done = 1'b1;
                o_event = kgc_pkg::EV_FN_LONG;
                o_key   = kgc_pkg::KEY_FN;
            end else if (i_flags.chord_active && !i_flags.chord_done &&
                         i_flags.key_pressed[0] && i_flags.key_pressed[1] &&
                         up_ge_long) begin
                o_flags.chord_done = 1'b1;
                o_event = kgc_pkg::EV_CHORD_REV;
            end else if (i_flags.chord_active) begin
                o_event = kgc_pkg::EV_NONE;
            end else if (i_flags.key_pressed[0] && !i_flags.key_holding[0] &&
                         ge_hold[0]) begin
                o_flags.key_holding[0] = 1'b1;
                o_event = kgc_pkg::EV_HOLD_BEG;
            end else if (i_flags.key_pressed[1] && !i_flags.key_holding[1] &&
                         ge_hold[1]) begin
                o_flags.key_holding[1] = 1'b1;
                o_event = kgc_pkg::EV_HOLD_BEG;
                o_key   = kgc_pkg::KEY_DN;
            end
        end else if (key == kgc_pkg::KEY_BAD) begin
            o_event = kgc_pkg::EV_NONE;
        end else if (i_item.is_press) begin
            // A press always restarts the key's timing
            o_flags.key_pressed[key] = 1'b1;
            o_flags.key_holding[key] = 1'b0;
            o_time_we[key]           = 1'b1;
            if (key == kgc_pkg::KEY_FN) begin
                o_flags.long_done = 1'b0;
            end else if (o_flags.key_pressed[0] && o_flags.key_pressed[1] &&
                         !i_flags.chord_active) begin
                // Chord start: retime both keys, close a running jog
                o_flags.chord_active = 1'b1;
                o_flags.chord_done   = 1'b0;
                o_time_we[1:0]       = 2'b11;
                if (i_flags.key_holding[other]) begin
                    o_flags.key_holding[other] = 1'b0;
                    o_event = kgc_pkg::EV_HOLD_END;
                    o_key   = other;
                end
            end
        end else if (i_flags.key_pressed[key]) begin
            o_flags.key_pressed[key] = 1'b0;
            if (i_flags.chord_active && key != kgc_pkg::KEY_FN) begin
                if (!o_flags.key_pressed[0] && !o_flags.key_pressed[1]) begin
                    o_flags.chord_active = 1'b0;
                end
            end else if (key == kgc_pkg::KEY_FN && i_flags.long_done) begin
                o_event = kgc_pkg::EV_NONE;
            end else if (i_flags.key_holding[key]) begin
                o_flags.key_holding[key] = 1'b0;
                o_event = kgc_pkg::EV_HOLD_END;
            end else if (key == kgc_pkg::KEY_FN) begin
                o_event = kgc_pkg::EV_TAP;
            end else if (!ge_hold[key[0]]) begin
                o_event = kgc_pkg::EV_TAP;
            end
        end
    end

endmodule

// ----- sv/keypad_gesture_classifier.sv -----
// Keypad gesture classifier: taps, jog holds, function long press and the
// up+down chord on three keys. The result register loads from the input register
// once free. Throughput: one request per cycle unless the event stream stalls;
// the single pass through kgc_core (three timestamp subtract-compares and flag
// logic) sets the cycle.
// Reset (i_rst_n low, synchronous) clears all flags and press times and
// loads the thresholds with 500 ms and 2000 ms.
module keypad_gesture_classifier #(
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [1:0] key_code, [2] is_press, [34:3] time_ms
    input  logic        i_s_tuser,   // [0] kind (1: time tick)

    // Event stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [1:0] event_key
    output logic [2:0]  o_m_tuser,   // [2:0] event_code

    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Thresholds
    logic [31:0] r_hold_thr;
    logic [31:0] r_long_thr;

    // Input register
    logic            r_in_valid;
    kgc_pkg::t_item  r_in;

    // Classifier state
    kgc_pkg::t_flags      r_flags;
    logic [TIME_BITS-1:0] r_press_time [3];

    // Result register
    logic            r_out_valid;
    kgc_pkg::t_event r_out_event;
    logic [1:0]      r_out_key;

    // Core outputs
    kgc_pkg::t_flags      n_flags;
    logic [2:0]           n_time_we;
    logic [TIME_BITS-1:0] n_now;
    kgc_pkg::t_event      n_event;
    logic [1:0]           n_key;

    logic out_free;
    logic advance;

    // The result register frees when empty or when taken this cycle; the
    // input register advances into it whenever it frees.
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;

    // Configuration must be written only while idle (the block itself does not enforce this), so always take it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_thr <= kgc_pkg::HOLD_THR_RST;
            r_long_thr <= kgc_pkg::LONG_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kgc_pkg::REG_HOLD_THR: r_hold_thr <= i_cfg_data;
                kgc_pkg::REG_LONG_THR: r_long_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture a request; hold it until the result register takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.kind     <= i_s_tuser;
            r_in.key_code <= i_s_tdata[1:0];
            r_in.is_press <= i_s_tdata[2];
            r_in.time_ms  <= i_s_tdata[34:3];
        end
    end

    kgc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_item       (r_in),
        .i_flags      (r_flags),
        .i_press_time (r_press_time),
        .i_hold_thr   (r_hold_thr),
        .i_long_thr   (r_long_thr),
        .o_flags      (n_flags),
        .o_time_we    (n_time_we),
        .o_now        (n_now),
        .o_event      (n_event),
        .o_key        (n_key)
    );

    // Commit state only when the request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            for (int k = 0; k < 3; k++) begin
                r_press_time[k] <= '0;
            end
        end else if (advance) begin
            r_flags <= n_flags;
            for (int k = 0; k < 3; k++) begin
                if (n_time_we[k]) begin
                    r_press_time[k] <= n_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= n_event;
            r_out_key   <= n_key;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_key};
    assign o_m_tuser  = r_out_event;

    // A key can only be holding while it is down
    a_hold_needs_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags.key_holding & ~r_flags.key_pressed) == 3'b000)
        else $error("holding flag set on a key that is up");

    // No jog hold runs while the chord is active
    a_chord_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.chord_active |-> (r_flags.key_holding[1:0] == 2'b00))
        else $error("jog hold running during chord");

    // A chord starts only with both up and down pressed
    a_chord_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flags.chord_active) |-> (r_flags.key_pressed[1:0] == 2'b11))
        else $error("chord latched without both keys down");

    // A stalled request stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input request lost while stalled");

    // Function long press always names the function key
    a_fn_long_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == kgc_pkg::EV_FN_LONG) |->
        r_out_key == kgc_pkg::KEY_FN)
        else $error("function long press on wrong key");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for keypad_gesture_classifier: randomized request and event streams,
// threshold writes between phases, and a request-level gesture predictor in the testbench.
// Depends on kgc_pkg (key codes, register indexes, event codes, request layout) and the RTL.
module tb;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic PRESS     = 1'b1;
    localparam logic RELEASE   = 1'b0;
    localparam int   CYCLE_LIMIT = 200000;

    typedef struct packed {
        kgc_pkg::t_event code;
        logic [1:0]      key;
    } t_gesture;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [39:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [7:0]  o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_cfg_ready;

    keypad_gesture_classifier uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    kgc_pkg::t_item pending_reqs[$];
    t_gesture       expected_events[$];
    kgc_pkg::t_item req_on_bus;
    int       errors = 0;
    int       cyc = 0;
    logic     quiet;
    logic [31:0] clock_ms = '0;

    // Predictor state, mirrors the block after reset
    logic [31:0] hold_thr = kgc_pkg::HOLD_THR_RST;
    logic [31:0] long_thr = kgc_pkg::LONG_THR_RST;
    logic [2:0]  key_is_down = '0;
    logic [2:0]  key_is_holding = '0;
    logic [31:0] press_ms [3] = '{default: '0};
    logic        fn_long_fired = 1'b0;
    logic        chord_on = 1'b0;
    logic        chord_sent = 1'b0;

    // Long stretches without any idling on either side
    assign quiet = (cyc % 3000) >= 2000;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cyc, msg);
        errors++;
    endtask

    function automatic logic [31:0] held_for(input logic [31:0] now, input logic [1:0] k);
        return now - press_ms[k];
    endfunction

    // Advance the gesture state by one request and return the event it causes
    function automatic t_gesture classify_gesture(input kgc_pkg::t_item it);
        t_gesture   g;
        logic [1:0] k;
        logic [1:0] other;
        logic [31:0] now;
        k = it.key_code;
        now = it.time_ms;
        g.code = kgc_pkg::EV_NONE;
        g.key = k;
        if (it.kind == KIND_TICK) begin
            g.key = kgc_pkg::KEY_UP;
            if (key_is_down[kgc_pkg::KEY_FN] && !fn_long_fired
                && held_for(now, kgc_pkg::KEY_FN) >= long_thr) begin
                fn_long_fired = 1'b1;
                g.code = kgc_pkg::EV_FN_LONG;
                g.key = kgc_pkg::KEY_FN;
            end else if (chord_on && !chord_sent && key_is_down[kgc_pkg::KEY_UP]
                         && key_is_down[kgc_pkg::KEY_DN]
                         && held_for(now, kgc_pkg::KEY_UP) >= long_thr) begin
                chord_sent = 1'b1;
                g.code = kgc_pkg::EV_CHORD_REV;
            end else if (!chord_on) begin
                // Up wins over down when both cross the hold threshold
                if (key_is_down[kgc_pkg::KEY_UP] && !key_is_holding[kgc_pkg::KEY_UP]
                    && held_for(now, kgc_pkg::KEY_UP) >= hold_thr) begin
                    key_is_holding[kgc_pkg::KEY_UP] = 1'b1;
                    g.code = kgc_pkg::EV_HOLD_BEG;
                end else if (key_is_down[kgc_pkg::KEY_DN] && !key_is_holding[kgc_pkg::KEY_DN]
                             && held_for(now, kgc_pkg::KEY_DN) >= hold_thr) begin
                    key_is_holding[kgc_pkg::KEY_DN] = 1'b1;
                    g.code = kgc_pkg::EV_HOLD_BEG;
                    g.key = kgc_pkg::KEY_DN;
                end
            end
            return g;
        end
        if (k == kgc_pkg::KEY_BAD)
            return g;
        if (it.is_press == PRESS) begin
            // A repeated press restarts the key
            key_is_down[k] = 1'b1;
            press_ms[k] = now;
            key_is_holding[k] = 1'b0;
            if (k == kgc_pkg::KEY_FN) begin
                fn_long_fired = 1'b0;
            end else if (key_is_down[kgc_pkg::KEY_UP] && key_is_down[kgc_pkg::KEY_DN]
                         && !chord_on) begin
                other = (k == kgc_pkg::KEY_UP) ? kgc_pkg::KEY_DN : kgc_pkg::KEY_UP;
                chord_on = 1'b1;
                chord_sent = 1'b0;
                press_ms[kgc_pkg::KEY_UP] = now;
                press_ms[kgc_pkg::KEY_DN] = now;
                // Close a jog already running on the other key
                if (key_is_holding[other]) begin
                    key_is_holding[other] = 1'b0;
                    g.code = kgc_pkg::EV_HOLD_END;
                    g.key = other;
                end
            end
            return g;
        end
        if (!key_is_down[k])
            return g;
        key_is_down[k] = 1'b0;
        if (chord_on && k != kgc_pkg::KEY_FN) begin
            if (!key_is_down[kgc_pkg::KEY_UP] && !key_is_down[kgc_pkg::KEY_DN])
                chord_on = 1'b0;
            return g;
        end
        if (k == kgc_pkg::KEY_FN && fn_long_fired)
            return g;
        if (key_is_holding[k]) begin
            key_is_holding[k] = 1'b0;
            g.code = kgc_pkg::EV_HOLD_END;
            return g;
        end
        // Late release of up or down without a hold gives nothing
        if (k == kgc_pkg::KEY_FN || held_for(now, k) < hold_thr)
            g.code = kgc_pkg::EV_TAP;
        return g;
    endfunction

    task automatic push_req(input logic kind, input logic [1:0] key, input logic press,
                            input logic [31:0] t);
        kgc_pkg::t_item it;
        it.kind = kind;
        it.key_code = key;
        it.is_press = press;
        it.time_ms = t;
        pending_reqs.push_back(it);
    endtask

    // Request driver: hold a request until accepted, then maybe idle
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_events.push_back(classify_gesture(req_on_bus));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
                    req_on_bus = pending_reqs.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {5'b0, req_on_bus.time_ms, req_on_bus.is_press,
                                  req_on_bus.key_code};
                    i_s_tuser <= req_on_bus.kind;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: stall at random, compare each accepted event with the oldest expectation
    always @(posedge i_clk) begin : event_check
        t_gesture want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || ($urandom_range(99) >= 35);
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    flag_mismatch("event with nothing expected");
                end else begin
                    want = expected_events.pop_front();
                    if (o_m_tuser !== want.code)
                        flag_mismatch($sformatf("event_code %0d, expected %0d",
                                                o_m_tuser, want.code));
                    if (o_m_tdata[1:0] !== want.key)
                        flag_mismatch($sformatf("event_key %0d, expected %0d",
                                                o_m_tdata[1:0], want.key));
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == kgc_pkg::REG_HOLD_THR)
            hold_thr = val;
        else
            long_thr = val;
    endtask

    // Wait until every request is accepted and every event has arrived
    task automatic drain();
        while (pending_reqs.size() != 0 || i_s_tvalid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_directed();
        push_req(KIND_KEY, kgc_pkg::KEY_BAD, PRESS, 32'd0);      // invalid key
        push_req(KIND_KEY, kgc_pkg::KEY_UP, RELEASE, 32'd1);     // release of a key not down
        push_req(KIND_KEY, kgc_pkg::KEY_UP, PRESS, 32'd10);
        push_req(KIND_KEY, kgc_pkg::KEY_UP, RELEASE, 32'd100);   // tap
        push_req(KIND_KEY, kgc_pkg::KEY_DN, PRESS, 32'd200);
        push_req(KIND_TICK, kgc_pkg::KEY_UP, RELEASE, 32'd700);  // hold start at threshold
        push_req(KIND_KEY, kgc_pkg::KEY_DN, RELEASE, 32'd800);   // hold end
        push_req(KIND_KEY, kgc_pkg::KEY_FN, PRESS, 32'd1000);
        push_req(KIND_TICK, kgc_pkg::KEY_BAD, PRESS, 32'd3000);  // function long press
        push_req(KIND_KEY, kgc_pkg::KEY_FN, RELEASE, 32'd3100);  // release after long press
        push_req(KIND_KEY, kgc_pkg::KEY_FN, PRESS, 32'd4000);
        push_req(KIND_KEY, kgc_pkg::KEY_FN, RELEASE, 32'd4100);  // function tap
        push_req(KIND_KEY, kgc_pkg::KEY_UP, PRESS, 32'd5000);
        push_req(KIND_KEY, kgc_pkg::KEY_UP, PRESS, 32'd5100);    // repeated press restarts
        push_req(KIND_KEY, kgc_pkg::KEY_UP, RELEASE, 32'd5700);  // late release
        push_req(KIND_KEY, kgc_pkg::KEY_UP, PRESS, 32'd6000);
        push_req(KIND_TICK, kgc_pkg::KEY_DN, PRESS, 32'd6500);   // up hold start
        push_req(KIND_KEY, kgc_pkg::KEY_DN, PRESS, 32'd6600);    // chord start closes the jog
        push_req(KIND_TICK, kgc_pkg::KEY_UP, RELEASE, 32'd8600); // chord reverse
        push_req(KIND_TICK, kgc_pkg::KEY_UP, RELEASE, 32'd8700); // chord active, nothing
        push_req(KIND_KEY, kgc_pkg::KEY_UP, RELEASE, 32'd8800);  // chord release
        push_req(KIND_KEY, kgc_pkg::KEY_DN, RELEASE, 32'd8900);  // chord ends
        push_req(KIND_KEY, kgc_pkg::KEY_UP, PRESS, 32'hFFFF_FFF0);
        push_req(KIND_KEY, kgc_pkg::KEY_UP, RELEASE, 32'h0000_0010); // tap across the wrap
        push_req(KIND_TICK, kgc_pkg::KEY_BAD, PRESS, 32'hFFFF_FFFF);
        clock_ms = 32'd20;
    endtask

    // Mostly well-formed key sessions: presses, ticks and releases with random timing,
    // plus a little noise (garbage requests, time jumps, spurious releases)
    task automatic gen_session(input int n, input int unsigned step_max);
        logic [2:0] held;
        logic [1:0] k;
        logic       pr;
        int         r;
        held = '0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 3)
                clock_ms = $urandom();
            else if (r < 8)
                clock_ms = clock_ms - $urandom_range(1, 3);
            else
                clock_ms = clock_ms + $urandom_range(0, step_max);
            r = $urandom_range(99);
            if (r < 6) begin
                push_req(1'($urandom_range(1)), 2'($urandom_range(3)),
                         1'($urandom_range(1)), $urandom());
            end else if (r < 45) begin
                push_req(KIND_TICK, 2'($urandom_range(3)), 1'($urandom_range(1)), clock_ms);
            end else begin
                k = 2'($urandom_range(2));
                if (r < 48)
                    k = kgc_pkg::KEY_BAD;
                if (k != kgc_pkg::KEY_BAD && held[k])
                    pr = ($urandom_range(9) == 0);
                else
                    pr = ($urandom_range(9) != 0);
                if (k != kgc_pkg::KEY_BAD)
                    held[k] = pr;
                push_req(KIND_KEY, k, pr, clock_ms);
            end
        end
    endtask

    initial begin
        int unsigned h;
        int unsigned l;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds
        load_directed();
        gen_session(300, 500);
        drain();

        // Zero thresholds: every press crosses at once
        write_reg(kgc_pkg::REG_HOLD_THR, 32'd0);
        write_reg(kgc_pkg::REG_LONG_THR, 32'd0);
        gen_session(250, 5);
        drain();

        // Maximum thresholds: only a tick one ms before the press gets there
        write_reg(kgc_pkg::REG_HOLD_THR, 32'hFFFF_FFFF);
        write_reg(kgc_pkg::REG_LONG_THR, 32'hFFFF_FFFF);
        push_req(KIND_KEY, kgc_pkg::KEY_FN, PRESS, 32'd100);
        push_req(KIND_TICK, kgc_pkg::KEY_UP, RELEASE, 32'd99);
        push_req(KIND_KEY, kgc_pkg::KEY_FN, RELEASE, 32'd120);
        push_req(KIND_KEY, kgc_pkg::KEY_DN, PRESS, 32'd200);
        push_req(KIND_TICK, kgc_pkg::KEY_UP, RELEASE, 32'd199);
        push_req(KIND_KEY, kgc_pkg::KEY_DN, RELEASE, 32'd300);
        clock_ms = 32'd300;
        gen_session(250, 100000);
        drain();

        // Short thresholds
        write_reg(kgc_pkg::REG_HOLD_THR, 32'd20);
        write_reg(kgc_pkg::REG_LONG_THR, 32'd60);
        gen_session(400, 25);
        drain();

        // Long press shorter than hold
        write_reg(kgc_pkg::REG_HOLD_THR, 32'd60);
        write_reg(kgc_pkg::REG_LONG_THR, 32'd20);
        gen_session(300, 25);
        drain();

        h = $urandom_range(1, 1000);
        l = $urandom_range(1, 4000);
        write_reg(kgc_pkg::REG_LONG_THR, l);
        write_reg(kgc_pkg::REG_HOLD_THR, h);
        gen_session(350, l / 4 + h / 4 + 1);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
